[rtl/core/cfs_pkg.sv]
// cfs_pkg: transaction types, request codes and fixed widths of the cyclic frame scheduler
// no dependencies; imported by cfs_frame_table, cyclic_frame_scheduler and tb
`default_nettype none

package cfs_pkg;

   localparam int TASK_W  = 4;
   localparam int MAP_W   = 16;
   localparam int SLICE_W = 16;
   localparam int EPOCH_W = 32;
   localparam int COUNT_W = 5;

   localparam logic [COUNT_W-1:0] READY_MAX = 5'd31;

   typedef enum logic [1:0] {
      REQ_PUSH      = 2'd0,
      REQ_POP       = 2'd1,
      REQ_TICK      = 2'd2,
      REQ_PUSH_IDLE = 2'd3
   } cfs_code_type;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CLAIM   = 6'b000010,
      ST_SCAN    = 6'b000100,
      ST_POP_LD  = 6'b001000,
      ST_TICK_LD = 6'b010000,
      ST_DONE    = 6'b100000
   } cfs_state_type;

   typedef struct packed {
      cfs_code_type        req_type;
      logic [TASK_W-1:0]   task_id;
      logic [MAP_W-1:0]    frame_map;
      logic [SLICE_W-1:0]  timeslice_ticks;
   } cfs_req_type;

   typedef struct packed {
      logic [TASK_W-1:0]   chosen_task;
      logic                chose_idle;
      logic                reschedule;
      logic                no_ready_owner;
      logic [EPOCH_W-1:0]  longest_idle_window;
   } cfs_rsp_type;

endpackage : cfs_pkg

`default_nettype wire

[rtl/core/cyclic_frame_scheduler.sv]
// cyclic_frame_scheduler: single cpu cyclic executive with frame ownership and timeslices
// top level; depends on cfs_pkg and cfs_frame_table
//
// usage
//   req channel carries one request transaction: push thread, pop next, tick or push idle
//   rsp channel returns exactly one result transaction per request, in request order
//   one request is worked on at a time; req_ready is high only while the block is waiting
//   path of each request from idle to done, where the result is loaded, receiver ready:
//     tick on idle, push idle, pop with nothing ready, ignored push : straight to done
//     push of a placed thread : straight to done; a first push with claimed frames sweeps
//       owner writes through every frame up to and including its highest claimed frame
//     tick on a thread : to done, via tick load when the slice reloads from the slice memory
//     pop : frame scan, then pop load and done, or done when no ready owner turns up;
//           the frame scan issues one owner memory read per cycle and evaluates it after
//   req_ready returns the cycle after the result is loaded
//   a finished result sits in the rsp register while the next request is accepted;
//   a stalled receiver holds the block only when a second result is ready to go out
//   reset (synchronous, active high) clears all ready, placed and frame valid bits,
//   the counters and pointers and the idle epoch, and starts with idle running;
//   no clearing pass runs, the block takes a request in the first cycle after reset
`default_nettype none

module cyclic_frame_scheduler #(
   parameter int NUM_FRAMES  = 16,
   parameter int NUM_THREADS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire cfs_pkg::cfs_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output cfs_pkg::cfs_rsp_type      rsp_data
);
   import cfs_pkg::*;

   localparam int FW = $clog2(NUM_FRAMES);
   localparam int TW = $clog2(NUM_THREADS);
   localparam int CW = $clog2(NUM_FRAMES + 1);

   localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);
   localparam logic [CW-1:0] SCAN_LAST  = CW'(NUM_FRAMES - 1);
   localparam logic [CW-1:0] SCAN_ALL   = CW'(NUM_FRAMES);

   // control state
   cfs_state_type          state_ff, state_in;
   logic [NUM_THREADS-1:0] ready_ff, ready_in;
   logic [NUM_THREADS-1:0] placed_ff, placed_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [FW-1:0]          next_frame_ff, next_frame_in;
   logic [TW-1:0]          run_thread_ff, run_thread_in;
   logic                   run_idle_ff, run_idle_in;
   logic [SLICE_W-1:0]     ticks_ff, ticks_in;
   logic [EPOCH_W-1:0]     epoch_ff, epoch_in;
   logic [EPOCH_W-1:0]     epoch_max_ff, epoch_max_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // claim sweep
   logic [TASK_W-1:0]      claim_task_ff, claim_task_in;
   logic [MAP_W-1:0]       claim_map_ff, claim_map_in;
   logic [FW-1:0]          claim_frame_ff, claim_frame_in;

   // frame scan pipeline: address issue, then owner evaluation
   logic [FW-1:0]          rd_addr_ff, rd_addr_in;
   logic [CW-1:0]          issue_cnt_ff, issue_cnt_in;
   logic                   eval_vld_ff, eval_vld_in;
   logic [FW-1:0]          eval_frame_ff, eval_frame_in;
   logic                   eval_last_ff, eval_last_in;
   logic [TW-1:0]          hit_thread_ff, hit_thread_in;
   logic [FW-1:0]          hit_frame_ff, hit_frame_in;

   // result registers
   cfs_rsp_type            res_ff, res_in;
   cfs_rsp_type            rsp_ff, rsp_in;

   // slice memory
   logic [SLICE_W-1:0]     slice_mem [NUM_THREADS];
   logic [SLICE_W-1:0]     slice_q_ff;
   logic                   slice_we;
   logic [TW-1:0]          slice_waddr;
   logic [TW-1:0]          slice_raddr;

   // frame table interface
   logic                   ft_set_en;
   logic [NUM_FRAMES-1:0]  ft_set_mask;
   logic                   ft_wr_en;
   logic [TASK_W-1:0]      ft_rd_owner;
   logic [NUM_FRAMES-1:0]  ft_valid;

   // decoded request and scan terms
   logic                   tid_ok;
   logic [TW-1:0]          tid_idx;
   logic [NUM_FRAMES-1:0]  map_frames;
   logic                   own_ok;
   logic [TW-1:0]          own_idx;
   logic                   scan_hit;
   logic [SLICE_W-1:0]     ticks_dec;
   logic [EPOCH_W-1:0]     epoch_inc;

   cfs_frame_table #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_frame_table (
      .clock       (clock),
      .reset       (reset),
      .set_en      (ft_set_en),
      .set_mask    (ft_set_mask),
      .wr_en       (ft_wr_en),
      .wr_addr     (claim_frame_ff),
      .wr_owner    (claim_task_ff),
      .rd_addr     (rd_addr_ff),
      .rd_owner    (ft_rd_owner),
      .frame_valid (ft_valid)
   );

   // slice memory: written on push, read for pop loads and slice reloads
   always_ff @(posedge clock) begin
      if (slice_we) begin
         slice_mem[slice_waddr] <= req_data.timeslice_ticks;
      end
      slice_q_ff <= slice_mem[slice_raddr];
   end

   assign tid_ok     = (32'(req_data.task_id) < NUM_THREADS);
   assign tid_idx    = TW'(req_data.task_id);
   // map bits beyond the frame count drop out here
   assign map_frames = NUM_FRAMES'(req_data.frame_map);

   assign own_ok   = (32'(ft_rd_owner) < NUM_THREADS);
   assign own_idx  = TW'(ft_rd_owner);
   assign scan_hit = eval_vld_ff & ft_valid[eval_frame_ff] & own_ok & ready_ff[own_idx];

   // slice countdown saturates at zero
   assign ticks_dec = (ticks_ff == '0) ? '0 : ticks_ff - 1'b1;
   // idle epoch wraps from all ones to zero
   assign epoch_inc = epoch_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      ready_in       = ready_ff;
      placed_in      = placed_ff;
      count_in       = count_ff;
      next_frame_in  = next_frame_ff;
      run_thread_in  = run_thread_ff;
      run_idle_in    = run_idle_ff;
      ticks_in       = ticks_ff;
      epoch_in       = epoch_ff;
      epoch_max_in   = epoch_max_ff;
      claim_task_in  = claim_task_ff;
      claim_map_in   = claim_map_ff;
      claim_frame_in = claim_frame_ff;
      rd_addr_in     = rd_addr_ff;
      issue_cnt_in   = issue_cnt_ff;
      eval_vld_in    = 1'b0;
      eval_frame_in  = eval_frame_ff;
      eval_last_in   = eval_last_ff;
      hit_thread_in  = hit_thread_ff;
      hit_frame_in   = hit_frame_ff;
      res_in         = res_ff;

      // rsp register drains independently of the work in flight
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_in         = rsp_ff;

      slice_we       = 1'b0;
      slice_waddr    = tid_idx;
      slice_raddr    = run_thread_ff;
      ft_set_en      = 1'b0;
      ft_set_mask    = map_frames;
      ft_wr_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in   = '0;
               state_in = ST_DONE;
               case (req_data.req_type)
                  REQ_PUSH: begin
                     // out of range thread ids are dropped
                     if (tid_ok) begin
                        slice_we          = 1'b1;
                        ready_in[tid_idx] = 1'b1;
                        if (count_ff != READY_MAX) begin
                           count_in = count_ff + 1'b1;
                        end
                        // first push claims its frames: valid bits now, owners swept
                        if (!placed_ff[tid_idx]) begin
                           placed_in[tid_idx] = 1'b1;
                           ft_set_en          = 1'b1;
                           claim_task_in      = req_data.task_id;
                           claim_map_in       = MAP_W'(map_frames);
                           claim_frame_in     = '0;
                           if (map_frames != '0) begin
                              state_in = ST_CLAIM;
                           end
                        end
                     end
                  end
                  REQ_POP: begin
                     if (count_ff == '0) begin
                        run_idle_in       = 1'b1;
                        res_in.chose_idle = 1'b1;
                     end else begin
                        rd_addr_in   = next_frame_ff;
                        issue_cnt_in = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  REQ_TICK: begin
                     if (run_idle_ff) begin
                        epoch_in = epoch_inc;
                        if (epoch_inc > epoch_max_ff) begin
                           epoch_max_in = epoch_inc;
                        end
                        res_in.reschedule = (count_ff != '0);
                     end else begin
                        ticks_in = ticks_dec;
                        if (ticks_dec == '0) begin
                           if (count_ff == '0) begin
                              // nobody waiting: reload the running thread's slice
                              state_in = ST_TICK_LD;
                           end else begin
                              res_in.reschedule = 1'b1;
                           end
                        end
                     end
                  end
                  default: begin
                     epoch_in = '0;
                  end
               endcase
            end
         end

         ST_CLAIM: begin
            // walk the frames, writing the owner where a claimed bit is set, done once none remain
            ft_wr_en       = claim_map_ff[0];
            claim_map_in   = claim_map_ff >> 1;
            claim_frame_in = claim_frame_ff + 1'b1;
            if (claim_map_ff[MAP_W-1:1] == '0) begin
               state_in = ST_DONE;
            end
         end

         ST_SCAN: begin
            if (scan_hit) begin
               hit_thread_in = own_idx;
               hit_frame_in  = eval_frame_ff;
               slice_raddr   = own_idx;
               state_in      = ST_POP_LD;
            end else if (eval_vld_ff && eval_last_ff) begin
               // every frame looked at, none owned by a ready thread
               res_in.no_ready_owner = 1'b1;
               state_in              = ST_DONE;
            end else if (issue_cnt_ff != SCAN_ALL) begin
               eval_vld_in   = 1'b1;
               eval_frame_in = rd_addr_ff;
               eval_last_in  = (issue_cnt_ff == SCAN_LAST);
               rd_addr_in    = (rd_addr_ff == LAST_FRAME) ? '0 : rd_addr_ff + 1'b1;
               issue_cnt_in  = issue_cnt_ff + 1'b1;
            end
         end

         ST_POP_LD: begin
            run_thread_in           = hit_thread_ff;
            run_idle_in             = 1'b0;
            ticks_in                = slice_q_ff;
            ready_in[hit_thread_ff] = 1'b0;
            next_frame_in           = (hit_frame_ff == LAST_FRAME) ? '0 : hit_frame_ff + 1'b1;
            count_in                = count_ff - 1'b1;
            res_in.chosen_task      = TASK_W'(hit_thread_ff);
            state_in                = ST_DONE;
         end

         ST_TICK_LD: begin
            ticks_in = slice_q_ff;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_in                      = res_ff;
               rsp_in.longest_idle_window  = epoch_max_ff;
               state_in                    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ready_ff      <= '0;
         placed_ff     <= '0;
         count_ff      <= '0;
         next_frame_ff <= '0;
         run_thread_ff <= '0;
         run_idle_ff   <= 1'b1;
         ticks_ff      <= '0;
         epoch_ff      <= '0;
         epoch_max_ff  <= '0;
         eval_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ready_ff      <= ready_in;
         placed_ff     <= placed_in;
         count_ff      <= count_in;
         next_frame_ff <= next_frame_in;
         run_thread_ff <= run_thread_in;
         run_idle_ff   <= run_idle_in;
         ticks_ff      <= ticks_in;
         epoch_ff      <= epoch_in;
         epoch_max_ff  <= epoch_max_in;
         eval_vld_ff   <= eval_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and sequencing registers
   always_ff @(posedge clock) begin
      claim_task_ff  <= claim_task_in;
      claim_map_ff   <= claim_map_in;
      claim_frame_ff <= claim_frame_in;
      rd_addr_ff     <= rd_addr_in;
      issue_cnt_ff   <= issue_cnt_in;
      eval_frame_ff  <= eval_frame_in;
      eval_last_ff   <= eval_last_in;
      hit_thread_ff  <= hit_thread_in;
      hit_frame_ff   <= hit_frame_in;
      res_ff         <= res_in;
      rsp_ff         <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule : cyclic_frame_scheduler

`default_nettype wire

[rtl/core/cfs_frame_table.sv]
// cfs_frame_table: frame owner memory (one write port, registered read) and frame valid bits
// depends on cfs_pkg
`default_nettype none

module cfs_frame_table #(
   parameter int NUM_FRAMES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          set_en,
   input  wire logic [NUM_FRAMES-1:0]         set_mask,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(NUM_FRAMES)-1:0] wr_addr,
   input  wire logic [cfs_pkg::TASK_W-1:0]    wr_owner,
   input  wire logic [$clog2(NUM_FRAMES)-1:0] rd_addr,
   output logic      [cfs_pkg::TASK_W-1:0]    rd_owner,
   output logic      [NUM_FRAMES-1:0]         frame_valid
);
   import cfs_pkg::*;

   logic [TASK_W-1:0]     owner_mem [NUM_FRAMES];
   logic [TASK_W-1:0]     rd_owner_ff;
   logic [NUM_FRAMES-1:0] valid_ff;

   // owner storage, read every cycle at the registered address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         owner_mem[wr_addr] <= wr_owner;
      end
      rd_owner_ff <= owner_mem[rd_addr];
   end

   // valid bits gate the owner entries, so the memory needs no clearing
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (set_en) begin
         valid_ff <= valid_ff | set_mask;
      end
   end

   assign rd_owner    = rd_owner_ff;
   assign frame_valid = valid_ff;

endmodule : cfs_frame_table

`default_nettype wire

[bench/tb.sv]
// tb: self-checking bench for cyclic_frame_scheduler, a directed table then random traffic
// depends on cfs_pkg and the scheduler rtl; checks each result in order, predicted or typed
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cfs_pkg::*;

   localparam int FRAMES   = 16;
   localparam int RAND_CNT = 600;
   localparam int HOLD_AT  = 200;   // accepted transactions before the long receiver hold
   localparam int HOLD_LEN = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   cfs_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   cfs_rsp_type rsp_data;

   cyclic_frame_scheduler uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // shadow copy of the scheduler state, advanced once per accepted request
   logic [TASK_W-1:0]  frame_owner_q [FRAMES];
   bit                 frame_claimed [FRAMES];
   bit                 task_ready    [16];
   bit                 task_placed   [16];
   logic [SLICE_W-1:0] task_slice    [16];
   logic [COUNT_W-1:0] ready_cnt;
   logic [TASK_W-1:0]  scan_start;
   logic [TASK_W-1:0]  cur_task;
   bit                 cur_is_idle;
   logic [SLICE_W-1:0] slice_left;
   logic [EPOCH_W-1:0] idle_epoch_cnt;
   logic [EPOCH_W-1:0] idle_epoch_peak;

   // results still owed by the block, oldest first
   cfs_rsp_type due_rsp [$];

   // one row of the directed table; typed rows carry their own expected result
   typedef struct {
      cfs_req_type req;
      bit          typed;
      cfs_rsp_type rsp;
   } stim_row_type;

   stim_row_type stim_rows [$];

   int errors;
   int n_accepted;
   int tx_pct;   // chance in a hundred that the sender idles a cycle
   int rx_pct;   // chance in a hundred that the receiver stalls a cycle

   // advance the shadow state by one request and return the result it causes
   function automatic cfs_rsp_type sched_step(input cfs_req_type r);
      cfs_rsp_type       o;
      logic [TASK_W-1:0] f;
      logic [TASK_W-1:0] owner;
      bit                found;
      o = '0;
      found = 1'b0;
      case (r.req_type)
         REQ_PUSH: begin
            // frames are claimed on the first push only, later pushes keep ownership
            if (!task_placed[r.task_id]) begin
               for (int i = 0; i < FRAMES; i++) begin
                  if (r.frame_map[i]) begin
                     frame_owner_q[i] = r.task_id;
                     frame_claimed[i] = 1'b1;
                  end
               end
               task_placed[r.task_id] = 1'b1;
            end
            task_slice[r.task_id] = r.timeslice_ticks;
            task_ready[r.task_id] = 1'b1;
            if (ready_cnt != READY_MAX) ready_cnt = ready_cnt + 1'b1;
         end
         REQ_POP: begin
            if (ready_cnt == '0) begin
               cur_is_idle = 1'b1;
               o.chose_idle = 1'b1;
            end else begin
               // circular scan from the next-frame pointer for a ready owner
               for (int i = 0; i < FRAMES; i++) begin
                  f = scan_start + TASK_W'(i);
                  owner = frame_owner_q[f];
                  if (!found && frame_claimed[f] && task_ready[owner]) begin
                     found = 1'b1;
                     cur_task = owner;
                     cur_is_idle = 1'b0;
                     slice_left = task_slice[owner];
                     task_ready[owner] = 1'b0;
                     scan_start = f + 1'b1;
                     ready_cnt = ready_cnt - 1'b1;
                     o.chosen_task = owner;
                  end
               end
               if (!found) o.no_ready_owner = 1'b1;
            end
         end
         REQ_TICK: begin
            if (cur_is_idle) begin
               idle_epoch_cnt = idle_epoch_cnt + 1'b1;   // wraps from all ones to zero
               if (idle_epoch_cnt > idle_epoch_peak) idle_epoch_peak = idle_epoch_cnt;
               o.reschedule = (ready_cnt != '0);
            end else begin
               if (slice_left != '0) slice_left = slice_left - 1'b1;
               if (slice_left == '0) begin
                  // nobody waiting: the running thread gets a fresh slice
                  if (ready_cnt == '0) slice_left = task_slice[cur_task];
                  else o.reschedule = 1'b1;
               end
            end
         end
         default: idle_epoch_cnt = '0;   // push idle
      endcase
      o.longest_idle_window = idle_epoch_peak;
      return o;
   endfunction

   task automatic add_row(input cfs_code_type op, input logic [TASK_W-1:0] tid,
                          input logic [MAP_W-1:0] fmap, input logic [SLICE_W-1:0] ticks,
                          input bit typed, input logic [TASK_W-1:0] ctask, input bit idle,
                          input bit resched, input bit nro, input logic [EPOCH_W-1:0] liw);
      stim_row_type row;
      row.req.req_type = op;
      row.req.task_id = tid;
      row.req.frame_map = fmap;
      row.req.timeslice_ticks = ticks;
      row.typed = typed;
      row.rsp.chosen_task = ctask;
      row.rsp.chose_idle = idle;
      row.rsp.reschedule = resched;
      row.rsp.no_ready_owner = nro;
      row.rsp.longest_idle_window = liw;
      stim_rows.push_back(row);
   endtask

   // random request: mostly small slices so ticks run slices out, often sparse maps so
   // threads keep some frames, and random filler in the fields that the operation ignores
   function automatic cfs_req_type rand_req(input bit push_only);
      cfs_req_type r;
      int          pick;
      r.task_id = TASK_W'($urandom_range(15));
      r.frame_map = MAP_W'($urandom_range(65535));
      case ($urandom_range(3))
         0: r.frame_map = 16'h0001 << $urandom_range(15);
         1: r.frame_map = (16'h0001 << $urandom_range(15)) | (16'h0001 << $urandom_range(15));
         default: ;
      endcase
      if ($urandom_range(9) < 8) r.timeslice_ticks = SLICE_W'($urandom_range(5));
      else r.timeslice_ticks = SLICE_W'($urandom_range(65535));
      pick = $urandom_range(99);
      if (push_only || pick < 36) r.req_type = REQ_PUSH;
      else if (pick < 66) r.req_type = REQ_POP;
      else if (pick < 96) r.req_type = REQ_TICK;
      else r.req_type = REQ_PUSH_IDLE;
      return r;
   endfunction

   // offer one transaction, hold it until accepted, then log what it must produce
   task automatic offer(input cfs_req_type r, input bit typed, input cfs_rsp_type want);
      cfs_rsp_type pred;
      @(negedge clock);
      while ($urandom_range(99) < tx_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = sched_step(r);
      due_rsp.push_back(typed ? want : pred);
      n_accepted++;
   endtask

   task automatic note_fail(input string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous wall: the slowest legal run needs well under a tenth of this
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random stalls per phase, plus one long hold so the block backs up
   initial begin : rsp_side
      int hold_cnt;
      bit hold_done;
      hold_cnt = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cnt > 0) begin
            rsp_ready <= 1'b0;
            hold_cnt--;
         end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_cnt = HOLD_LEN - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !($urandom_range(99) < rx_pct);
         end
      end
   end

   // result checker: every result transaction against the oldest expectation
   always @(posedge clock) begin : rsp_check
      cfs_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp.size() == 0) begin
            note_fail($sformatf("result with nothing expected: %p", rsp_data));
         end else begin
            want = due_rsp.pop_front();
            if (rsp_data.chosen_task !== want.chosen_task ||
                rsp_data.chose_idle !== want.chose_idle ||
                rsp_data.reschedule !== want.reschedule ||
                rsp_data.no_ready_owner !== want.no_ready_owner ||
                rsp_data.longest_idle_window !== want.longest_idle_window)
               note_fail($sformatf(
                  "mismatch task %0d/%0d idle %0b/%0b resched %0b/%0b nro %0b/%0b win %0d/%0d",
                  want.chosen_task, rsp_data.chosen_task, want.chose_idle, rsp_data.chose_idle,
                  want.reschedule, rsp_data.reschedule, want.no_ready_owner,
                  rsp_data.no_ready_owner, want.longest_idle_window,
                  rsp_data.longest_idle_window));
         end
      end
   end

   // stimulus: reset, directed table, random phases, drain
   initial begin : stim
      cfs_rsp_type no_rsp;
      int          phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      errors = 0;
      n_accepted = 0;
      tx_pct = 0;
      rx_pct = 0;
      no_rsp = '0;

      for (int i = 0; i < FRAMES; i++) begin
         frame_owner_q[i] = '0;
         frame_claimed[i] = 1'b0;
      end
      for (int i = 0; i < 16; i++) begin
         task_ready[i] = 1'b0;
         task_placed[i] = 1'b0;
         task_slice[i] = '0;
      end
      ready_cnt = '0;
      scan_start = '0;
      cur_task = '0;
      cur_is_idle = 1'b1;
      slice_left = '0;
      idle_epoch_cnt = '0;
      idle_epoch_peak = '0;

      // idle after reset: epoch, empty pop, idle push
      add_row(REQ_TICK,      4'd0,  16'h0000, 16'h0000, 1, 4'd0, 0, 0, 0, 32'd1);
      add_row(REQ_POP,       4'd0,  16'h0000, 16'h0000, 1, 4'd0, 1, 0, 0, 32'd1);
      add_row(REQ_PUSH_IDLE, 4'd0,  16'h0000, 16'h0000, 1, 4'd0, 0, 0, 0, 32'd1);
      add_row(REQ_TICK,      4'd0,  16'h0000, 16'h0000, 1, 4'd0, 0, 0, 0, 32'd1);
      // top thread takes every frame with the longest slice, thread 0 then steals frame 0
      add_row(REQ_PUSH,      4'd15, 16'hFFFF, 16'hFFFF, 1, 4'd0, 0, 0, 0, 32'd1);
      add_row(REQ_PUSH,      4'd0,  16'h0001, 16'h0000, 1, 4'd0, 0, 0, 0, 32'd1);
      // idle tick with threads waiting asks for a reschedule
      add_row(REQ_TICK,      4'd0,  16'h0000, 16'h0000, 1, 4'd0, 0, 1, 0, 32'd2);
      // pops in frame order, zero slice, long slice countdown
      add_row(REQ_POP,       4'd0,  16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0, 32'd0);
      add_row(REQ_TICK,      4'd0,  16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0, 32'd0);
      add_row(REQ_POP,       4'd0,  16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0, 32'd0);
      add_row(REQ_TICK,      4'd0,  16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0, 32'd0);
      // repush of a placed thread ignores its map; the scan wraps back to frame 0
      add_row(REQ_PUSH,      4'd0,  16'hFFFE, 16'h0002, 0, 4'd0, 0, 0, 0, 32'd0);
      add_row(REQ_POP,       4'd0,  16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0, 32'd0);
      // slice runs out with nobody waiting: reload, no reschedule
      add_row(REQ_TICK,      4'd0,  16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0, 32'd0);
      add_row(REQ_TICK,      4'd0,  16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0, 32'd0);
      add_row(REQ_TICK,      4'd0,  16'h0000, 16'h0000, 0, 4'd0, 0, 0, 0, 32'd0);
      // back to idle, new epoch peak
      add_row(REQ_POP,       4'd0,  16'h0000, 16'h0000, 1, 4'd0, 1, 0, 0, 32'd2);
      add_row(REQ_TICK,      4'd0,  16'h0000, 16'h0000, 1, 4'd0, 0, 0, 0, 32'd3);
      add_row(REQ_PUSH_IDLE, 4'd0,  16'h0000, 16'h0000, 1, 4'd0, 0, 0, 0, 32'd3);
      // thread with no frames: ready but unreachable, pop reports no ready owner
      add_row(REQ_PUSH,      4'd7,  16'h0000, 16'h0001, 1, 4'd0, 0, 0, 0, 32'd3);
      add_row(REQ_POP,       4'd0,  16'h0000, 16'h0000, 1, 4'd0, 0, 0, 1, 32'd3);
      add_row(REQ_TICK,      4'd0,  16'h0000, 16'h0000, 1, 4'd0, 0, 1, 0, 32'd3);
      // push of a thread that is already ready still counts
      add_row(REQ_PUSH,      4'd7,  16'h0000, 16'h0001, 1, 4'd0, 0, 0, 0, 32'd3);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) offer(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp);

      // random part in phases of 75: none, sender idles, receiver stalls, both
      for (int k = 0; k < RAND_CNT; k++) begin
         phase = (k / 75) % 4;
         tx_pct = (phase == 1) ? 46 : (phase == 3) ? 19 : 0;
         rx_pct = (phase == 2) ? 46 : (phase == 3) ? 19 : 0;
         // a push burst drives the ready count into saturation
         offer(rand_req(k >= 280 && k < 330), 1'b0, no_rsp);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      // wait on past the longest pop so that a stray result is caught
      repeat (40) @(posedge clock);

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
